[src/smc_pkg.sv]
// Shared types, constants and helpers for the sample mean and covariance unit.
`timescale 1ns / 1ps
package smc_pkg;

  localparam int DEF_MAX_DIM     = 4;
  localparam int DEF_MAX_SAMPLES = 256;
  // Divisor and remainder width: covers sample counts up to 8191 and dims up to 7.
  localparam int DIVR_W = 13;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SINGLE = 2'd1;
  localparam logic [1:0] ST_INCOMP = 2'd2;
  localparam logic [1:0] ST_OVF    = 2'd3;

  localparam logic KIND_MEAN = 1'b0;
  localparam logic KIND_COV  = 1'b1;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               last_of_data;
  } in_item_t;

  typedef struct packed {
    logic               entry_kind;
    logic [1:0]         row_index;
    logic [1:0]         col_index;
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic               last_result;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] dividend;
    logic [DIVR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] quot;
    logic [DIVR_W-1:0]  rem;
  } div_resp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[src/smc_store.sv]
// Sample buffer: one write port and two registered read ports.
`timescale 1ns / 1ps
module smc_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic signed [31:0]       wr_data,
  input  logic [ADDR_W-1:0]        rd_addr_a,
  input  logic [ADDR_W-1:0]        rd_addr_b,
  output logic signed [31:0]       rd_data_a,
  output logic signed [31:0]       rd_data_b
);
  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end
endmodule

[src/smc_divider.sv]
// Iterative restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module smc_divider (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smc_pkg::div_req_t    req,
  output smc_pkg::div_resp_t   resp
);
  import smc_pkg::*;

  logic              run_r, run_nxt;
  logic [5:0]        step_r, step_nxt;
  logic [63:0]       dvd_r, dvd_nxt;
  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [DIVR_W-1:0] dvs_r, dvs_nxt;
  logic              neg_r, neg_nxt;
  logic              done_r, done_nxt;
  logic [DIVR_W:0]   trial;
  logic [63:0]       qmag;

  assign trial = {rem_r, dvd_r[63]};
  assign qmag  = dvd_r;

  always_comb begin
    run_nxt  = run_r;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (req.start) begin
      run_nxt  = 1'b1;
      step_nxt = '0;
      neg_nxt  = req.dividend[63];
      dvd_nxt  = req.dividend[63] ? 64'(-req.dividend) : 64'(req.dividend);
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (run_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIVR_W'(trial - {1'b0, dvs_r});
        dvd_nxt = {dvd_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVR_W-1:0];
        dvd_nxt = {dvd_r[62:0], 1'b0};
      end
      step_nxt = step_r + 6'd1;
      if (step_r == 6'd63) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
  end

  assign resp.done = done_r;
  assign resp.quot = neg_r ? -$signed(qmag) : $signed(qmag);
  assign resp.rem  = rem_r;
endmodule

[src/sample_mean_covariance_unit.sv]
// Top level: sample loading, mean and covariance sequencer around a shared datapath.
// Loading takes one element per cycle; busy stays low until the flagged last element.
// After it, a divide checks the count, each mean sums its samples and divides, and each
// covariance entry loads two means, accumulates deviation products over the samples and divides.
// Results come out one per strobe cycle and cannot be stalled; busy drops with the last.
// Reset (synchronous, active low) clears the sample count, overflow flag, strobe and sequencer; dim_r goes to 1.
`timescale 1ns / 1ps
module sample_mean_covariance_unit #(
  parameter int MAX_DIM     = smc_pkg::DEF_MAX_DIM,
  parameter int MAX_SAMPLES = smc_pkg::DEF_MAX_SAMPLES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  smc_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output smc_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_data
);
  import smc_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_SAMPLES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int N_W    = $clog2(MAX_SAMPLES + 1);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_CNTW = 13'b0000000000010,
    S_MRD  = 13'b0000000000100,
    S_MADD = 13'b0000000001000,
    S_MDIV = 13'b0000000010000,
    S_CMJ  = 13'b0000000100000,
    S_CMK  = 13'b0000001000000,
    S_CRD  = 13'b0000010000000,
    S_CDEV = 13'b0000100000000,
    S_CML  = 13'b0001000000000,
    S_CMH  = 13'b0010000000000,
    S_CACC = 13'b0100000000000,
    S_CDIV = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0]         dim_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic [DIM_W-1:0]   d_r, d_nxt;
  logic [N_W-1:0]     n_r, n_nxt;
  logic [N_W-1:0]     i_r, i_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [DIM_W-1:0]   j_r, j_nxt, k_r, k_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [31:0] mj_r, mj_nxt, mk_r, mk_nxt;
  logic [32:0]        ma_r, ma_nxt, mb_r, mb_nxt;
  logic               neg_r, neg_nxt;
  logic [49:0]        p0_r, p0_nxt;
  logic [48:0]        p1_r, p1_nxt;
  logic signed [31:0] mean_r [MAX_DIM];
  logic               mean_we;
  logic signed [31:0] mean_wd;
  out_item_t          out_r, out_nxt;
  logic               strobe_r, strobe_nxt;

  logic [DIM_W-1:0]   eff_d;
  logic [CNT_W-1:0]   cap;
  logic               accept, wr_en;
  logic [ADDR_W-1:0]  rd_a, rd_b;
  logic signed [31:0] rd_da, rd_db;
  div_req_t           dreq;
  div_resp_t          dresp;
  logic               last_entry;
  logic signed [32:0] dev_j, dev_k;
  logic [65:0]        prod_m;
  logic [49:0]        prod_q;
  logic signed [63:0] prod_s;
  logic signed [64:0] sum65;
  logic signed [63:0] acc_sat;

  assign eff_d = (dim_r == 3'd0) ? DIM_W'(1)
               : ({{(32-3){1'b0}}, dim_r} > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(dim_r);
  assign cap    = CNT_W'(eff_d) * CNT_W'(MAX_SAMPLES);
  assign accept = start && !busy;
  assign wr_en  = accept && (cnt_r < cap);
  assign rd_a   = base_r + ADDR_W'(j_r);
  assign rd_b   = base_r + ADDR_W'(k_r);
  assign last_entry = (j_r == d_r - DIM_W'(1)) && (k_r == d_r - DIM_W'(1));

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);

  smc_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (cnt_r[ADDR_W-1:0]),
    .wr_data   (in_item.sample_value),
    .rd_addr_a (rd_a),
    .rd_addr_b (rd_b),
    .rd_data_a (rd_da),
    .rd_data_b (rd_db)
  );

  smc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .resp  (dresp)
  );

  // Deviation product, floor of (dj*dk)/2^16, added with 64-bit saturation.
  assign dev_j  = 33'(rd_da) - 33'(mj_r);
  assign dev_k  = 33'(rd_db) - 33'(mk_r);
  assign prod_m = 66'(p0_r) + (66'(p1_r) << 17);
  assign prod_q = prod_m[65:16] + 50'(neg_r && (prod_m[15:0] != 16'd0));
  assign prod_s = neg_r ? -$signed({14'd0, prod_q}) : $signed({14'd0, prod_q});
  assign sum65  = 65'(acc_r) + 65'(prod_s);
  assign acc_sat = (sum65 > 65'sh0_7FFF_FFFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF_FFFF
                 : (sum65 < -65'sh0_8000_0000_0000_0000) ? 64'sh8000_0000_0000_0000
                 : sum65[63:0];

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    d_nxt      = d_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    base_nxt   = base_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    acc_nxt    = acc_r;
    mj_nxt     = mj_r;
    mk_nxt     = mk_r;
    ma_nxt     = ma_r;
    mb_nxt     = mb_r;
    neg_nxt    = neg_r;
    p0_nxt     = p0_r;
    p1_nxt     = p1_r;
    out_nxt    = out_r;
    strobe_nxt = 1'b0;
    mean_we    = 1'b0;
    mean_wd    = sat32(dresp.quot);
    dreq.start    = 1'b0;
    dreq.dividend = acc_r;
    dreq.divisor  = DIVR_W'(n_r);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (wr_en) cnt_nxt = cnt_r + CNT_W'(1);
          else ovf_nxt = 1'b1;
          if (in_item.last_of_data) begin
            d_nxt         = eff_d;
            dreq.start    = 1'b1;
            dreq.dividend = 64'(cnt_nxt);
            dreq.divisor  = DIVR_W'(eff_d);
            state_nxt     = S_CNTW;
          end
        end
      end
      S_CNTW: begin
        if (dresp.done) begin
          if (ovf_r || (dresp.rem != '0)) begin
            out_nxt    = '{KIND_MEAN, 2'd0, 2'd0, 32'sd0,
                           ovf_r ? ST_OVF : ST_INCOMP, 1'b1};
            strobe_nxt = 1'b1;
            cnt_nxt    = '0;
            ovf_nxt    = 1'b0;
            state_nxt  = S_IDLE;
          end else begin
            n_nxt     = dresp.quot[N_W-1:0];
            j_nxt     = '0;
            i_nxt     = '0;
            base_nxt  = '0;
            acc_nxt   = '0;
            state_nxt = S_MRD;
          end
        end
      end
      S_MRD: state_nxt = S_MADD;
      S_MADD: begin
        acc_nxt  = acc_r + 64'(rd_da);
        i_nxt    = i_r + N_W'(1);
        base_nxt = base_r + ADDR_W'(d_r);
        if (i_r == n_r - N_W'(1)) begin
          dreq.start    = 1'b1;
          dreq.dividend = acc_nxt;
          state_nxt     = S_MDIV;
        end else begin
          state_nxt = S_MRD;
        end
      end
      S_MDIV: begin
        if (dresp.done) begin
          mean_we    = 1'b1;
          out_nxt    = '{KIND_MEAN, 2'(j_r), 2'd0, sat32(dresp.quot), ST_OK, 1'b0};
          strobe_nxt = 1'b1;
          i_nxt      = '0;
          base_nxt   = '0;
          acc_nxt    = '0;
          if (j_r == d_r - DIM_W'(1)) begin
            j_nxt     = '0;
            k_nxt     = '0;
            state_nxt = S_CMJ;
          end else begin
            j_nxt     = j_r + DIM_W'(1);
            state_nxt = S_MRD;
          end
        end
      end
      S_CMJ: begin
        mj_nxt    = mean_r[j_r[IDX_W-1:0]];
        state_nxt = S_CMK;
      end
      S_CMK: begin
        mk_nxt   = mean_r[k_r[IDX_W-1:0]];
        i_nxt    = '0;
        base_nxt = '0;
        acc_nxt  = '0;
        if (n_r == N_W'(1)) begin
          // A single sample gives no covariance: zero entries flagged.
          out_nxt    = '{KIND_COV, 2'(j_r), 2'(k_r), 32'sd0, ST_SINGLE, last_entry};
          strobe_nxt = 1'b1;
          state_nxt  = S_CMJ;
          if (k_r == d_r - DIM_W'(1)) begin
            k_nxt = '0;
            j_nxt = j_r + DIM_W'(1);
          end else begin
            k_nxt = k_r + DIM_W'(1);
          end
          if (last_entry) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_CRD;
        end
      end
      S_CRD: state_nxt = S_CDEV;
      S_CDEV: begin
        ma_nxt    = dev_j[32] ? 33'(-dev_j) : 33'(dev_j);
        mb_nxt    = dev_k[32] ? 33'(-dev_k) : 33'(dev_k);
        neg_nxt   = dev_j[32] ^ dev_k[32];
        state_nxt = S_CML;
      end
      S_CML: begin
        p0_nxt    = 50'(ma_r) * 50'(mb_r[16:0]);
        state_nxt = S_CMH;
      end
      S_CMH: begin
        p1_nxt    = 49'(ma_r) * 49'(mb_r[32:17]);
        state_nxt = S_CACC;
      end
      S_CACC: begin
        acc_nxt  = acc_sat;
        i_nxt    = i_r + N_W'(1);
        base_nxt = base_r + ADDR_W'(d_r);
        if (i_r == n_r - N_W'(1)) begin
          dreq.start    = 1'b1;
          dreq.dividend = acc_sat;
          dreq.divisor  = DIVR_W'(n_r - N_W'(1));
          state_nxt     = S_CDIV;
        end else begin
          state_nxt = S_CRD;
        end
      end
      S_CDIV: begin
        if (dresp.done) begin
          out_nxt    = '{KIND_COV, 2'(j_r), 2'(k_r), sat32(dresp.quot), ST_OK, last_entry};
          strobe_nxt = 1'b1;
          state_nxt  = S_CMJ;
          if (k_r == d_r - DIM_W'(1)) begin
            k_nxt = '0;
            j_nxt = j_r + DIM_W'(1);
          end else begin
            k_nxt = k_r + DIM_W'(1);
          end
          if (last_entry) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      dim_r    <= 3'd1;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_valid && cfg_ready) dim_r <= cfg_data;
    end
    d_r    <= d_nxt;
    n_r    <= n_nxt;
    i_r    <= i_nxt;
    base_r <= base_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    acc_r  <= acc_nxt;
    mj_r   <= mj_nxt;
    mk_r   <= mk_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    neg_r  <= neg_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    out_r  <= out_nxt;
    if (mean_we) mean_r[j_r[IDX_W-1:0]] <= mean_wd;
  end

  assign out_strobe = strobe_r;
  assign out_item   = out_r;
endmodule

[src/smc_checker.sv]
// Port-level assertions for the sample mean and covariance unit, with its bind.
`timescale 1ns / 1ps
module smc_port_props (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input smc_pkg::out_item_t out_item
);
  import smc_pkg::*;

  // The final result of a run releases the block in the same cycle.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.last_result |-> !busy)
    else $error("busy still high with the final result");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last_result |-> busy)
    else $error("result before the end of a run while idle");

  a_no_result_midset: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !$past(busy) && !$past(out_strobe) |-> !out_strobe)
    else $error("result while loading a data set");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_item.status == ST_INCOMP || out_item.status == ST_OVF)
    |-> out_item.last_result && out_item.result_value == 32'sd0)
    else $error("error result is not a lone zero result");

  a_mean_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.entry_kind == KIND_MEAN |-> out_item.col_index == 2'd0)
    else $error("mean entry with a nonzero column");
endmodule

bind sample_mean_covariance_unit smc_port_props u_smc_port_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
